@@ hw/rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, codes and widths of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int ACT_W        = 3;
    localparam int POS_W        = 6;
    localparam int VAL_W        = 8;
    localparam int ST_W         = 2;
    localparam int LEN_W        = 6;
    localparam int DEF_CAPACITY = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int HITS_W       = $clog2(MAX_RESULTS + 1);
    localparam int CMD_DEPTH    = 2;
    localparam int RES_DEPTH    = 2;

    typedef enum logic [ACT_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_FIND   = 3'd3,
        OP_LENGTH = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_FIND = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t               action;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  entry_value;
        logic [POS_W-1:0]  entry_position;
        logic [LEN_W-1:0]  list_length;
        logic              last;
    } res_t;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

endpackage

@@ hw/rtl/sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of byte entries with insert, delete, read, find and length.
// ----------------------------------------------------------------------------
// Usage: items enter through a queue-style port (push/full) carrying action,
// position and value; results leave through a queue-style port (empty/pop)
// carrying status, entry_value, entry_position, list_length and last.
// An item lands in a two-entry command queue; the back end executes it from
// there once the result queue has room and writes its first result into the
// result queue, from which it shows on the ports. Insert, delete, read and
// length each give one result; find gives one result per match reported (at
// most 32) or one not-found result. Insert and delete move every later entry
// at once through the shift cells; the find scan emits the lowest pending
// match each cycle while the result queue is not full.
// Unused action codes are accepted and dropped.
// Reset clears the length to zero and empties both queues. When the receiver
// stops popping, the two-entry result queue fills, the back end holds, then
// the command queue fills and full rises.
// ----------------------------------------------------------------------------
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [ACT_W-1:0] action,
    input  logic [POS_W-1:0] position,
    input  logic [VAL_W-1:0] value,
    output logic             empty,
    input  logic             pop,
    output logic [ST_W-1:0]  status,
    output logic [VAL_W-1:0] entry_value,
    output logic [POS_W-1:0] entry_position,
    output logic [LEN_W-1:0] list_length,
    output logic             last
);

    logic             cmd_valid, cmd_pop;
    cmd_t             cmd;
    logic             res_push, res_full;
    res_t             res_in, res_out;
    logic [RES_W-1:0] res_bits;

    sle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .position  (position),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    sle_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    sle_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_out        = res_t'(res_bits);
    assign status         = res_out.status;
    assign entry_value    = res_out.entry_value;
    assign entry_position = res_out.entry_position;
    assign list_length    = res_out.list_length;
    assign last           = res_out.last;

endmodule

@@ hw/rtl/sle_fifo.sv @@
// ----------------------------------------------------------------------------
// sle_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module sle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             do_wr, do_rd;

    assign full    = (fill_reg == NW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/sle_front.sv @@
// ----------------------------------------------------------------------------
// sle_front
// Accepts items, drops unused action codes and queues the rest as commands.
// ----------------------------------------------------------------------------
module sle_front
    import sle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [ACT_W-1:0] action,
    input  logic [POS_W-1:0] position,
    input  logic [VAL_W-1:0] value,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  logic             cmd_pop
);

    cmd_t             cmd_in;
    logic             known_op;
    logic             cmd_empty;
    logic [CMD_W-1:0] cmd_bits;

    // codes past report-length are accepted and discarded
    assign known_op        = (action <= OP_LENGTH);
    assign cmd_in.action   = op_t'(action);
    assign cmd_in.position = position;
    assign cmd_in.value    = value;

    sle_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && known_op),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_bits),
        .empty   (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = !cmd_empty;

endmodule

@@ hw/rtl/sle_back.sv @@
// ----------------------------------------------------------------------------
// sle_back
// List cells with shift-up and shift-down, command execution and match scan.
// ----------------------------------------------------------------------------
module sle_back
    import sle_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VAL_W-1:0]    cells_reg [CAPACITY];
    logic [CW-1:0]       count_reg, count_next;
    back_state_t         state_reg, state_next;
    logic [CAPACITY-1:0] hits_reg, hits_next;
    logic [HITS_W-1:0]   nres_reg, nres_next;

    logic [XW-1:0]       pos_x, cnt_x, pm1;
    logic                pos_ok_rd, pos_ok_ins, list_full;
    logic [VAL_W-1:0]    read_val;
    logic [CAPACITY-1:0] match_vec, scan_vec, low_bit, rest_vec;
    logic [IW-1:0]       low_idx;
    logic [POS_W-1:0]    hit_pos;
    logic                ins_en, del_en;

    assign pos_x      = XW'(cmd.position);
    assign cnt_x      = XW'(count_reg);
    assign pm1        = pos_x - 1'b1;
    assign pos_ok_rd  = (pos_x != '0) && (pos_x <= cnt_x);
    assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
    assign list_full  = (cnt_x >= XW'(CAPACITY));

    always_comb
    begin
        read_val = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            if (XW'(j) == pm1)
            begin
                read_val = read_val | cells_reg[j];
            end
            match_vec[j] = (cells_reg[j] == cmd.value) && (XW'(j) < cnt_x);
        end
    end

    // lowest pending match goes out first
    assign scan_vec = (state_reg == BK_FIND) ? hits_reg : match_vec;
    assign low_bit  = scan_vec & (~scan_vec + 1'b1);
    assign rest_vec = scan_vec & ~low_bit;

    always_comb
    begin
        low_idx = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            if (low_bit[j])
            begin
                low_idx = low_idx | IW'(j);
            end
        end
    end

    assign hit_pos = POS_W'(CW'(low_idx) + 1'b1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        hits_next  = hits_reg;
        nres_next  = nres_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        ins_en     = 1'b0;
        del_en     = 1'b0;
        res        = '0;
        res.status = ST_OK;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    res_push = 1'b1;
                    res.last = 1'b1;
                    case (cmd.action)
                        OP_INSERT:
                        begin
                            if (list_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else if (!pos_ok_ins)
                            begin
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                ins_en     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!pos_ok_rd)
                            begin
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                del_en     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (!pos_ok_rd)
                            begin
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                res.entry_value    = read_val;
                                res.entry_position = cmd.position;
                            end
                        end
                        OP_FIND:
                        begin
                            if (match_vec == '0)
                            begin
                                res.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                res.entry_value    = cmd.value;
                                res.entry_position = hit_pos;
                                res.last           = (rest_vec == '0);
                                if (rest_vec != '0)
                                begin
                                    cmd_pop    = 1'b0;
                                    hits_next  = rest_vec;
                                    nres_next  = HITS_W'(1);
                                    state_next = BK_FIND;
                                end
                            end
                        end
                        OP_LENGTH:
                        begin
                            res.status = ST_OK;
                        end
                        default:
                        begin
                            res_push = 1'b0;
                        end
                    endcase
                end
            end
            BK_FIND:
            begin
                if (!res_full)
                begin
                    res_push           = 1'b1;
                    res.entry_value    = cmd.value;
                    res.entry_position = hit_pos;
                    // report stops at the result limit
                    res.last  = (rest_vec == '0) || (nres_reg == HITS_W'(MAX_RESULTS - 1));
                    hits_next = rest_vec;
                    nres_next = nres_reg + 1'b1;
                    if (res.last)
                    begin
                        cmd_pop    = 1'b1;
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        res.list_length = LEN_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            hits_reg  <= '0;
            nres_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hits_reg  <= hits_next;
            nres_reg  <= nres_next;
        end
    end

    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        logic [VAL_W-1:0] prev_val, succ_val, cell_next;

        if (j == 0)
        begin : g_first
            assign prev_val = '0;
        end
        else
        begin : g_mid_lo
            assign prev_val = cells_reg[j-1];
        end

        if (j == CAPACITY - 1)
        begin : g_top
            assign succ_val = '0;
        end
        else
        begin : g_mid_hi
            assign succ_val = cells_reg[j+1];
        end

        always_comb
        begin
            cell_next = cells_reg[j];
            if (ins_en)
            begin
                if (XW'(j) == pm1)
                begin
                    cell_next = cmd.value;
                end
                else if ((XW'(j) > pm1) && (XW'(j) <= cnt_x))
                begin
                    cell_next = prev_val;
                end
            end
            else if (del_en && (XW'(j) >= pm1) && (XW'(j) + 1'b1 < cnt_x))
            begin
                cell_next = succ_val;
            end
        end

        always_ff @(posedge clk)
        begin
            cells_reg[j] <= cell_next;
        end
    end

endmodule

@@ hw/rtl/sle_checker.sv @@
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker
    import sle_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [ST_W-1:0]  status,
    input logic [VAL_W-1:0] entry_value,
    input logic [POS_W-1:0] entry_position,
    input logic [LEN_W-1:0] list_length,
    input logic             last
);

    // both queues are cleared by reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queue not cleared by reset");

    // a stalled result holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status) && $stable(entry_value)
            && $stable(entry_position) && $stable(list_length) && $stable(last))
        else $error("stalled result changed");

    // error results stand alone and carry no entry
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (status != ST_OK) |-> last && (entry_value == '0)
            && (entry_position == '0))
        else $error("error result malformed");

    // a find report keeps the searched value across its results
    a_find_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last |=> empty
            || ((status == ST_OK) && (entry_value == $past(entry_value))
                && (entry_position != '0)))
        else $error("find report broken");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .entry_value    (entry_value),
    .entry_position (entry_position),
    .list_length    (list_length),
    .last           (last)
);
